>>> src/deq_pkg.sv
// Shared types and constants for the double-ended queue unit.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int OP_W      = 2;
    localparam int COUNT_W   = 5;
    localparam int IN_W      = 40;
    localparam int OUT_W     = 72;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } deq_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } deq_state_t;

    typedef struct packed {
        logic exec;
        logic rd_en;
        logic load;
    } deq_cmd_t;

endpackage

>>> src/deq_ram.sv
// Generic RAM, one write port and two registered read ports.
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> src/deq_ctrl.sv
// Sequencer for the double-ended queue: accept, read back, load result.
`timescale 1ns / 1ps

module deq_ctrl
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output deq_cmd_t cmd
);

    deq_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // output register must be free or draining this cycle
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> src/deq_dpath.sv
// Datapath: pointers, element count, ring store and result register.
`timescale 1ns / 1ps

module deq_dpath
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  deq_cmd_t                   cmd,
    input  logic [OP_W-1:0]            opcode,
    input  logic signed [WORD_W-1:0]   value,
    output logic                       ok,
    output logic signed [WORD_W-1:0]   front_value,
    output logic signed [WORD_W-1:0]   back_value,
    output logic [COUNT_W-1:0]         count,
    output logic                       is_empty,
    output logic [$clog2(DEPTH+1)-1:0] elem_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;

    logic                     ok_reg;
    logic signed [WORD_W-1:0] front_reg;
    logic signed [WORD_W-1:0] back_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic                     empty_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] head_dec, head_inc, tail_dec, tail_inc;
    logic [WORD_W-1:0] rd_front, rd_back;
    logic [CW+COUNT_W-1:0] cnt_ext;
    deq_op_t op;

    assign op       = deq_op_t'(opcode);
    assign head_dec = (head_reg == '0) ? LAST : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST : tail_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        we        = 1'b0;
        waddr     = tail_reg;
        if (cmd.exec)
        begin
            done_next = 1'b0;
            case (op)
                OP_PUSH_FRONT:
                begin
                    if (cnt_reg != FULL)
                    begin
                        head_next = head_dec;
                        waddr     = head_dec;
                        we        = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                        done_next = 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (cnt_reg != FULL)
                    begin
                        tail_next = tail_inc;
                        we        = 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                        done_next = 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (cnt_reg != '0)
                    begin
                        head_next = head_inc;
                        cnt_next  = cnt_reg - 1'b1;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    if (cnt_reg != '0)
                    begin
                        tail_next = tail_dec;
                        cnt_next  = cnt_reg - 1'b1;
                        done_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (value),
        .re      (cmd.rd_en),
        .raddr_a (head_reg),
        .raddr_b (tail_dec),
        .rdata_a (rd_front),
        .rdata_b (rd_back)
    );

    assign cnt_ext = {{COUNT_W{1'b0}}, cnt_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ok_reg    <= done_reg;
            front_reg <= (cnt_reg == '0) ? '0 : rd_front;
            back_reg  <= (cnt_reg == '0) ? '0 : rd_back;
            count_reg <= cnt_ext[COUNT_W-1:0];
            empty_reg <= (cnt_reg == '0);
        end
    end

    assign ok          = ok_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;
    assign count       = count_reg;
    assign is_empty    = empty_reg;
    assign elem_count  = cnt_reg;

endmodule

>>> src/double_ended_queue_unit.sv
// Top level of the double-ended queue unit.
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH signed 32-bit words in a ring store.
// Each input beat is one operation (push front, push back, pop front, pop
// back) and yields exactly one output beat with ok (0 when a push meets a
// full queue or a pop an empty one), the front and back words (0 when
// empty), the element count and an empty flag. An operation runs from
// acceptance through pointer update and store write, the registered read
// of the front and back slots, then the result load, which waits until the
// output register is free or draining; no new beat is taken before that
// load. The result waits in an output register, so the next beat is
// accepted while it is pending. No clearing pass: stale reads are masked.

module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [1:0] opcode, [33:2] value, [39:34] zero
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [0] ok, [32:1] front_value, [64:33] back_value, [69:65] count,
    // [70] is_empty, [71] zero
    output logic [OUT_W-1:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);

    deq_cmd_t              cmd;
    logic                  ok;
    logic signed [WORD_W-1:0] front_value, back_value;
    logic [COUNT_W-1:0]    count;
    logic                  is_empty;
    logic [CW-1:0]         elem_count;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (s_tdata[OP_W-1:0]),
        .value       (s_tdata[OP_W+WORD_W-1:OP_W]),
        .ok          (ok),
        .front_value (front_value),
        .back_value  (back_value),
        .count       (count),
        .is_empty    (is_empty),
        .elem_count  (elem_count)
    );

    assign m_tdata = {1'b0, is_empty, count, back_value, front_value, ok};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, elem_count} <= (CW+1)'(DEPTH))
        else $error("element count above depth");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while an operation is in flight");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        elem_count != $past(elem_count) |->
            ({1'b0, elem_count} == {1'b0, $past(elem_count)} + 1'b1 ||
             {1'b0, elem_count} + 1'b1 == {1'b0, $past(elem_count)}))
        else $error("element count moved by more than one");

endmodule

>>> tb/sv/double_ended_queue_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for double_ended_queue_unit: push/pop beats checked against a deque predictor.
module double_ended_queue_unit_tb;
    import deq_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int RANDOM_OPS = 1630;

    typedef struct packed {
        deq_op_t     op;
        logic [31:0] value;
        int          gap;
    } deq_item_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] front;
        logic [31:0] back;
        logic [4:0]  count;
        logic        is_empty;
    } deq_result_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    deq_item_t   op_queue[$];
    deq_result_t expected_results[$];
    deq_item_t   next_item;
    deq_result_t exp_res;

    logic [31:0] model_ring [DEPTH];
    int          model_head  = 0;
    int          model_tail  = 0;
    int          model_count = 0;

    int          err_count  = 0;
    int          gap_left   = 0;
    bit          gap_armed  = 1'b0;
    bit          src_calm   = 1'b0;
    int          stall_left = 0;
    bit          sink_calm  = 1'b0;

    double_ended_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic deq_result_t deque_apply(deq_op_t op, logic [31:0] value);
        deq_result_t r;
        logic        done;
        int          last;
        done = 1'b0;
        case (op)
            OP_PUSH_FRONT:
                if (model_count < DEPTH)
                begin
                    model_head = (model_head == 0) ? DEPTH - 1 : model_head - 1;
                    model_ring[model_head] = value;
                    model_count++;
                    done = 1'b1;
                end
            OP_PUSH_BACK:
                if (model_count < DEPTH)
                begin
                    model_ring[model_tail] = value;
                    model_tail = (model_tail + 1 >= DEPTH) ? 0 : model_tail + 1;
                    model_count++;
                    done = 1'b1;
                end
            OP_POP_FRONT:
                if (model_count > 0)
                begin
                    model_head = (model_head + 1 >= DEPTH) ? 0 : model_head + 1;
                    model_count--;
                    done = 1'b1;
                end
            default:
                if (model_count > 0)
                begin
                    model_tail = (model_tail == 0) ? DEPTH - 1 : model_tail - 1;
                    model_count--;
                    done = 1'b1;
                end
        endcase
        last       = (model_tail == 0) ? DEPTH - 1 : model_tail - 1;
        r.ok       = done;
        r.count    = model_count[4:0];
        r.is_empty = (model_count == 0);
        r.front    = (model_count == 0) ? 32'd0 : model_ring[model_head];
        r.back     = (model_count == 0) ? 32'd0 : model_ring[last];
        return r;
    endfunction

    task automatic add_op(deq_op_t op, logic [31:0] value);
        deq_item_t it;
        if ($urandom_range(0, 29) == 0)
            src_calm = !src_calm;
        it.op    = op;
        it.value = value;
        it.gap   = src_calm ? 0 : $urandom_range(0, 19);
        op_queue.push_back(it);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(deque_apply(deq_op_t'(s_tdata[1:0]), s_tdata[33:2]));
            if (!s_tvalid || s_tready)
            begin
                if (op_queue.size() > 0 && !gap_armed)
                begin
                    gap_left  = op_queue[0].gap;
                    gap_armed = 1'b1;
                end
                if (op_queue.size() > 0 && gap_left == 0)
                begin
                    next_item = op_queue.pop_front();
                    gap_armed = 1'b0;
                    s_tdata  <= {6'b0, next_item.value, next_item.op};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected beat: expected none, actual %h", $time, m_tdata);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    check_field("ok", {31'b0, exp_res.ok}, {31'b0, m_tdata[0]});
                    check_field("front_value", exp_res.front, m_tdata[32:1]);
                    check_field("back_value", exp_res.back, m_tdata[64:33]);
                    check_field("count", {27'b0, exp_res.count}, {27'b0, m_tdata[69:65]});
                    check_field("is_empty", {31'b0, exp_res.is_empty}, {31'b0, m_tdata[70]});
                end
                if ($urandom_range(0, 29) == 0)
                    sink_calm = !sink_calm;
                stall_left = sink_calm ? 0 : $urandom_range(0, 19);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int      mode;
        int      seg_left;
        int      push_pct;
        deq_op_t op;
        mode     = 2;
        seg_left = 0;

        // empty pops, extremes, fill to full, refused pushes at both ends
        add_op(OP_POP_FRONT, 32'hFFFF_FFFF);
        add_op(OP_POP_BACK, 32'h1234_5678);
        add_op(OP_PUSH_BACK, 32'h7FFF_FFFF);
        add_op(OP_PUSH_FRONT, 32'h8000_0000);
        add_op(OP_POP_BACK, 32'h0);
        add_op(OP_POP_FRONT, 32'h0);
        add_op(OP_PUSH_FRONT, 32'h0000_0000);
        add_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
        add_op(OP_PUSH_FRONT, 32'hAAAA_AAAA);
        add_op(OP_PUSH_BACK, 32'h5555_5555);
        add_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        add_op(OP_PUSH_BACK, 32'h8000_0000);
        for (int i = 0; i < DEPTH - 6; i++)
            add_op((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom);
        add_op(OP_PUSH_FRONT, $urandom);
        add_op(OP_PUSH_BACK, $urandom);

        // fill, drain and mixed stretches so full and empty come up often
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(10, 50);
            end
            seg_left--;
            push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            add_op(op, $urandom);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/deq_dpath.sv
src/double_ended_queue_unit.sv
tb/sv/double_ended_queue_unit_tb.sv
